FILE: rtl/lorp_pkg.sv
// Shared types, codes and defaults for the layer occlusion redraw planner.
package lorp_pkg;

  localparam int DEF_MAX_LAYERS = 8;
  localparam int DEF_COORD_BITS = 13;

  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_REMOVE  = 3'd1;
  localparam logic [2:0] REQ_CONFIG  = 3'd2;
  localparam logic [2:0] REQ_UPDATE  = 3'd3;
  localparam logic [2:0] REQ_COMPOSE = 3'd4;
  localparam logic [2:0] REQ_QUERY   = 3'd5;

  localparam logic [2:0] KIND_ACK  = 3'd0;
  localparam logic [2:0] KIND_COPY = 3'd1;
  localparam logic [2:0] KIND_BLIT = 3'd2;
  localparam logic [2:0] KIND_FLIP = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ERR,
    OP_ADD_INIT,
    OP_ADD_STEP,
    OP_ADD_COMMIT,
    OP_REMOVE,
    OP_CFG,
    OP_RC_LOAD,
    OP_RC_STEP,
    OP_RC_WRITE,
    OP_UPDATE,
    OP_ACK,
    OP_QUERY,
    OP_CMP_INIT,
    OP_CMP_STEP
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_SCAN,
    ST_CFG_CHK,
    ST_RC_LOAD,
    ST_RC_STEP,
    ST_UPD_CHK,
    ST_CMP_STEP,
    ST_CMP_FLIP
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   flip;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       slot_ok;
    logic       full;
    logic       scan_done;
    logic       changed;
    logic       p_done;
    logic       q_done;
    logic       one_layer;
  } dp_sts_t;

endpackage

FILE: rtl/lorp_ctrl.sv
// Request sequencer for the layer occlusion redraw planner.
module lorp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  lorp_pkg::dp_sts_t sts,
  output lorp_pkg::dp_cmd_t cmd,
  output logic             busy
);
  import lorp_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.flip  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (sts.req)
          REQ_ADD: begin
            if (sts.full) begin
              cmd.op = OP_ERR;
            end else begin
              cmd.op    = OP_ADD_INIT;
              state_nxt = ST_ADD_SCAN;
            end
          end
          REQ_REMOVE: begin
            cmd.op = sts.slot_ok ? OP_REMOVE : OP_ERR;
          end
          REQ_CONFIG: begin
            if (sts.slot_ok) begin
              cmd.op    = OP_CFG;
              state_nxt = ST_CFG_CHK;
            end else begin
              cmd.op = OP_ERR;
            end
          end
          REQ_UPDATE: begin
            if (sts.slot_ok) begin
              cmd.op    = OP_UPDATE;
              state_nxt = ST_UPD_CHK;
            end else begin
              cmd.op = OP_ERR;
            end
          end
          REQ_COMPOSE: begin
            cmd.op    = OP_CMP_INIT;
            state_nxt = ST_CMP_STEP;
          end
          REQ_QUERY: begin
            cmd.op = sts.slot_ok ? OP_QUERY : OP_ERR;
          end
          default: begin
            cmd.op = OP_ERR;
          end
        endcase
      end
      ST_ADD_SCAN: begin
        if (sts.scan_done) begin
          cmd.op    = OP_ADD_COMMIT;
          state_nxt = ST_IDLE;
        end else begin
          cmd.op = OP_ADD_STEP;
        end
      end
      ST_CFG_CHK: begin
        if (sts.changed) begin
          state_nxt = ST_RC_LOAD;
        end else begin
          cmd.op    = OP_ACK;
          state_nxt = ST_IDLE;
        end
      end
      ST_RC_LOAD: begin
        if (sts.p_done) begin
          cmd.op    = OP_ACK;
          state_nxt = ST_IDLE;
        end else begin
          cmd.op    = OP_RC_LOAD;
          state_nxt = ST_RC_STEP;
        end
      end
      ST_RC_STEP: begin
        if (sts.q_done) begin
          cmd.op    = OP_RC_WRITE;
          state_nxt = ST_RC_LOAD;
        end else begin
          cmd.op = OP_RC_STEP;
        end
      end
      ST_UPD_CHK: begin
        if (sts.one_layer) begin
          cmd.op    = OP_CMP_INIT;
          state_nxt = ST_CMP_STEP;
        end else begin
          cmd.op    = OP_ACK;
          state_nxt = ST_IDLE;
        end
      end
      ST_CMP_STEP: begin
        if (sts.p_done) begin
          cmd.op    = OP_NONE;
          cmd.flip  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.op = OP_CMP_STEP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/lorp_dp.sv
// Layer table, stacking list, flag and blit-count storage with output register.
module lorp_dp #(
  parameter int MAX_LAYERS = lorp_pkg::DEF_MAX_LAYERS,
  parameter int COORD_BITS = lorp_pkg::DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lorp_pkg::dp_cmd_t     cmd,
  output lorp_pkg::dp_sts_t     sts,
  input  logic [2:0]            in_req_type,
  input  logic [2:0]            in_slot,
  input  logic [7:0]            in_layer_depth,
  input  logic [COORD_BITS-1:0] in_left,
  input  logic [COORD_BITS-1:0] in_top,
  input  logic [COORD_BITS-1:0] in_right,
  input  logic [COORD_BITS-1:0] in_bottom,
  input  logic                  in_buffer_present,
  output logic                  out_valid,
  output logic [2:0]            out_kind,
  output logic [2:0]            out_layer_slot,
  output logic [31:0]           out_frames_shown,
  output logic                  out_last
);
  import lorp_pkg::*;

  localparam int NSLOT  = (MAX_LAYERS < 8) ? MAX_LAYERS : 8;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam int CNT_W  = $clog2(NSLOT + 1);
  localparam int F_UPD  = 0;
  localparam int F_SGL  = 1;
  localparam int F_HID  = 2;
  localparam int F_BUF  = 3;

  // request word
  logic [2:0]            req_r;
  logic [2:0]            slot_r;
  logic [7:0]            depth_r;
  logic [COORD_BITS-1:0] nl_r, nt_r, nr_r, nb_r;
  logic                  buf_r;

  // table
  logic                  used_r  [NSLOT];
  logic                  used_nxt[NSLOT];
  logic [3:0]            flags_r  [NSLOT];
  logic [3:0]            flags_nxt[NSLOT];
  logic [SLOT_W-1:0]     stack_r  [NSLOT];
  logic [SLOT_W-1:0]     stack_nxt[NSLOT];
  logic [7:0]            key_r  [NSLOT];
  logic [7:0]            key_nxt[NSLOT];
  logic [COORD_BITS-1:0] rl_r[NSLOT], rt_r[NSLOT], rr_r[NSLOT], rb_r[NSLOT];
  logic [COORD_BITS-1:0] rl_nxt[NSLOT], rt_nxt[NSLOT], rr_nxt[NSLOT], rb_nxt[NSLOT];
  logic [31:0]           blit_r  [NSLOT];
  logic [31:0]           blit_nxt[NSLOT];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  hpf_r, hpf_nxt;

  // sequencing
  logic [CNT_W-1:0]      p_r, p_nxt, q_r, q_nxt;
  logic [SLOT_W-1:0]     s_r, s_nxt;
  logic [COORD_BITS-1:0] sl_r, st_r, sr_r, sb_r;
  logic [COORD_BITS-1:0] sl_nxt, st_nxt, sr_nxt, sb_nxt;
  logic                  single_r, single_nxt, hide_r, hide_nxt, upper_r, upper_nxt;
  logic                  changed_r, changed_nxt;

  logic                  ov_nxt, last_nxt;
  logic [2:0]            kind_nxt, oslot_nxt;
  logic [31:0]           frames_nxt;

  logic [SLOT_W-1:0]     slot_idx, free_s, p_sl, lq, cs;
  logic                  free_found, slot_ok, rm_found;
  logic [CNT_W-1:0]      qi, rm_pos;
  logic                  ovl, ins;
  logic [3:0]            cf;
  logic                  c_upd, c_sgl;

  assign slot_idx = slot_r[SLOT_W-1:0];
  assign slot_ok  = ({1'b0, slot_r} < 4'(NSLOT)) && used_r[slot_idx];
  assign p_sl     = p_r[SLOT_W-1:0];
  assign qi       = q_r - CNT_W'(1);
  assign lq       = stack_r[qi[SLOT_W-1:0]];
  assign cs       = stack_r[p_sl];
  assign cf       = flags_r[cs];
  assign c_upd    = cf[F_UPD];
  assign c_sgl    = cf[F_SGL];

  assign ovl = !((sr_r <= rl_r[lq]) || (sl_r >= rr_r[lq]) ||
                 (sb_r <= rt_r[lq]) || (st_r >= rb_r[lq]));
  assign ins = (sl_r >= rl_r[lq]) && (sr_r <= rr_r[lq]) &&
               (st_r >= rt_r[lq]) && (sb_r <= rb_r[lq]);

  always_comb begin
    free_found = 1'b0;
    free_s     = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_s     = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rm_found = 1'b0;
    rm_pos   = cnt_r;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < cnt_r) && (stack_r[i] == slot_idx)) begin
        rm_found = 1'b1;
        rm_pos   = CNT_W'(i);
      end
    end
  end

  always_comb begin
    sts.req       = req_r;
    sts.slot_ok   = slot_ok;
    sts.full      = !free_found || (cnt_r >= CNT_W'(NSLOT));
    sts.scan_done = (p_r >= cnt_r) || (key_r[stack_r[p_sl]] > depth_r);
    sts.changed   = changed_r;
    sts.p_done    = (p_r >= cnt_r);
    sts.q_done    = (q_r == '0) || hide_r;
    sts.one_layer = (cnt_r == CNT_W'(1));
  end

  always_comb begin
    used_nxt  = used_r;
    flags_nxt = flags_r;
    stack_nxt = stack_r;
    key_nxt   = key_r;
    rl_nxt    = rl_r;
    rt_nxt    = rt_r;
    rr_nxt    = rr_r;
    rb_nxt    = rb_r;
    blit_nxt  = blit_r;
    cnt_nxt   = cnt_r;
    hpf_nxt   = hpf_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    s_nxt     = s_r;
    sl_nxt    = sl_r;
    st_nxt    = st_r;
    sr_nxt    = sr_r;
    sb_nxt    = sb_r;
    single_nxt  = single_r;
    hide_nxt    = hide_r;
    upper_nxt   = upper_r;
    changed_nxt = changed_r;
    ov_nxt     = 1'b0;
    kind_nxt   = KIND_ACK;
    oslot_nxt  = 3'd0;
    frames_nxt = 32'd0;
    last_nxt   = 1'b0;

    if (cmd.flip) begin
      ov_nxt   = 1'b1;
      kind_nxt = KIND_FLIP;
      last_nxt = 1'b1;
      hpf_nxt  = 1'b1;
    end

    case (cmd.op)
      OP_NONE: begin
      end
      OP_LATCH: begin
      end
      OP_ERR: begin
        ov_nxt   = 1'b1;
        kind_nxt = KIND_ERR;
        last_nxt = 1'b1;
      end
      OP_ADD_INIT: begin
        p_nxt = '0;
      end
      OP_ADD_STEP: begin
        p_nxt = p_r + CNT_W'(1);
      end
      OP_ADD_COMMIT: begin
        // open a hole at the scan position and drop the new slot in
        for (int i = 1; i < NSLOT; i++) begin
          if ((CNT_W'(i) > p_r) && (CNT_W'(i) <= cnt_r)) begin
            stack_nxt[i] = stack_r[i-1];
          end
        end
        stack_nxt[p_sl]  = free_s;
        cnt_nxt          = cnt_r + CNT_W'(1);
        used_nxt[free_s] = 1'b1;
        rl_nxt[free_s]   = nl_r;
        rt_nxt[free_s]   = nt_r;
        rr_nxt[free_s]   = nr_r;
        rb_nxt[free_s]   = nb_r;
        key_nxt[free_s]  = depth_r;
        flags_nxt[free_s] = 4'd0;
        blit_nxt[free_s] = 32'd0;
        ov_nxt    = 1'b1;
        kind_nxt  = KIND_ACK;
        oslot_nxt = 3'(free_s);
        last_nxt  = 1'b1;
      end
      OP_REMOVE: begin
        for (int i = 0; i < NSLOT - 1; i++) begin
          if ((CNT_W'(i) >= rm_pos) && (CNT_W'(i + 1) < cnt_r)) begin
            stack_nxt[i] = stack_r[i+1];
          end
        end
        if (rm_found) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        used_nxt[slot_idx]  = 1'b0;
        flags_nxt[slot_idx] = 4'd0;
        ov_nxt   = 1'b1;
        kind_nxt = KIND_ACK;
        last_nxt = 1'b1;
      end
      OP_CFG: begin
        changed_nxt = (rl_r[slot_idx] != nl_r) || (rt_r[slot_idx] != nt_r) ||
                      (rr_r[slot_idx] != nr_r) || (rb_r[slot_idx] != nb_r);
        key_nxt[slot_idx] = depth_r;
        rl_nxt[slot_idx]  = nl_r;
        rt_nxt[slot_idx]  = nt_r;
        rr_nxt[slot_idx]  = nr_r;
        rb_nxt[slot_idx]  = nb_r;
        p_nxt = '0;
      end
      OP_RC_LOAD: begin
        s_nxt      = cs;
        sl_nxt     = rl_r[cs];
        st_nxt     = rt_r[cs];
        sr_nxt     = rr_r[cs];
        sb_nxt     = rb_r[cs];
        q_nxt      = cnt_r;
        single_nxt = 1'b1;
        hide_nxt   = 1'b0;
        upper_nxt  = 1'b1;
      end
      OP_RC_STEP: begin
        // walk the list from the top down, one entry a step
        q_nxt = qi;
        if (qi == p_r) begin
          upper_nxt = 1'b0;
        end else begin
          if (single_r && ovl) begin
            single_nxt = 1'b0;
          end
          if ((!single_r || ovl) && !hide_r && upper_r && ins) begin
            hide_nxt = 1'b1;
          end
        end
      end
      OP_RC_WRITE: begin
        flags_nxt[s_r] = {flags_r[s_r][F_BUF], hide_r, single_r, 1'b0};
        p_nxt = p_r + CNT_W'(1);
      end
      OP_UPDATE: begin
        flags_nxt[slot_idx] = {buf_r, flags_r[slot_idx][F_HID],
                               flags_r[slot_idx][F_SGL], 1'b1};
      end
      OP_ACK: begin
        ov_nxt   = 1'b1;
        kind_nxt = KIND_ACK;
        last_nxt = 1'b1;
      end
      OP_QUERY: begin
        ov_nxt     = 1'b1;
        kind_nxt   = KIND_ACK;
        oslot_nxt  = slot_r;
        frames_nxt = blit_r[slot_idx];
        last_nxt   = 1'b1;
      end
      OP_CMP_INIT: begin
        p_nxt     = '0;
        upper_nxt = 1'b0;
        if ((cnt_r >= CNT_W'(2)) && hpf_r) begin
          ov_nxt   = 1'b1;
          kind_nxt = KIND_COPY;
        end
      end
      OP_CMP_STEP: begin
        p_nxt = p_r + CNT_W'(1);
        if (cf[F_BUF] && !cf[F_HID] && !(c_sgl && !c_upd)) begin
          upper_nxt = upper_r || (c_upd && !c_sgl);
          frames_nxt = blit_r[cs];
          if (c_upd && (blit_r[cs] != 32'hFFFF_FFFF)) begin
            frames_nxt = blit_r[cs] + 32'd1;
          end
          blit_nxt[cs] = frames_nxt;
          if (c_upd || upper_r || !c_sgl) begin
            ov_nxt    = c_upd || upper_r || (c_upd && !c_sgl);
            kind_nxt  = KIND_BLIT;
            oslot_nxt = 3'(cs);
          end
          flags_nxt[cs] = {cf[3:1], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        used_r[i]  <= 1'b0;
        flags_r[i] <= 4'd0;
      end
      cnt_r     <= '0;
      hpf_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      used_r    <= used_nxt;
      flags_r   <= flags_nxt;
      cnt_r     <= cnt_nxt;
      hpf_r     <= hpf_nxt;
      out_valid <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      req_r   <= in_req_type;
      slot_r  <= in_slot;
      depth_r <= in_layer_depth;
      nl_r    <= in_left;
      nt_r    <= in_top;
      nr_r    <= in_right;
      nb_r    <= in_bottom;
      buf_r   <= in_buffer_present;
    end
    stack_r   <= stack_nxt;
    key_r     <= key_nxt;
    rl_r      <= rl_nxt;
    rt_r      <= rt_nxt;
    rr_r      <= rr_nxt;
    rb_r      <= rb_nxt;
    blit_r    <= blit_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    s_r       <= s_nxt;
    sl_r      <= sl_nxt;
    st_r      <= st_nxt;
    sr_r      <= sr_nxt;
    sb_r      <= sb_nxt;
    single_r  <= single_nxt;
    hide_r    <= hide_nxt;
    upper_r   <= upper_nxt;
    changed_r <= changed_nxt;
    out_kind         <= kind_nxt;
    out_layer_slot   <= oslot_nxt;
    out_frames_shown <= frames_nxt;
    out_last         <= last_nxt;
  end

endmodule

FILE: rtl/layer_occlusion_redraw_planner_core.sv
// Top level of the layer occlusion redraw planner: sequencer plus layer datapath.
//
// Usage: drive a request word on the in_ ports and raise start; the word is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the last result word of that request has been issued.
// Results come out one word per cycle on the out_ ports, marked by out_valid;
// out_last flags the final word of a request. The receiver cannot stall, so
// every word is taken in the cycle it appears.
// An add scans the stacking list one entry a cycle to find its place.
// A configure that moves a rectangle rechecks each layer against every other
// one a step at a time through the shared overlap/containment comparator.
// A compose pass visits each listed layer in stacking order; an update on a
// lone layer runs a compose pass.
// Throughput: one request at a time; the next request may be accepted in the
// cycle the last word is shown.
// Reset (rst_n low, synchronous) empties the table, clears all layer flags
// and forgets the previous frame; slot contents are rewritten by add.
module layer_occlusion_redraw_planner_core #(
  parameter int MAX_LAYERS = lorp_pkg::DEF_MAX_LAYERS,
  parameter int COORD_BITS = lorp_pkg::DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_req_type,
  input  logic [2:0]            in_slot,
  input  logic [7:0]            in_layer_depth,
  input  logic [COORD_BITS-1:0] in_left,
  input  logic [COORD_BITS-1:0] in_top,
  input  logic [COORD_BITS-1:0] in_right,
  input  logic [COORD_BITS-1:0] in_bottom,
  input  logic                  in_buffer_present,
  output logic                  out_valid,
  output logic [2:0]            out_kind,
  output logic [2:0]            out_layer_slot,
  output logic [31:0]           out_frames_shown,
  output logic                  out_last
);
  import lorp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: walks each request through its steps
  lorp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: layer table, stacking list and result register
  lorp_dp #(
    .MAX_LAYERS (MAX_LAYERS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_slot           (in_slot),
    .in_layer_depth    (in_layer_depth),
    .in_left           (in_left),
    .in_top            (in_top),
    .in_right          (in_right),
    .in_bottom         (in_bottom),
    .in_buffer_present (in_buffer_present),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_layer_slot    (out_layer_slot),
    .out_frames_shown  (out_frames_shown),
    .out_last          (out_last)
  );

`ifndef ASSERT_OFF
  // the closing word of a request is issued as the sequencer returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("last word while busy");

  // a word that is not the last one leaves the request still in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("non-last word after finish");

  // a flip always closes its compose pass
  a_flip_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FLIP) |-> out_last) else $error("flip not last");

  // an accepted request keeps the block busy for at least the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");
`endif

endmodule

FILE: tb/sv/lorp_checker.sv
// Checker for the layer occlusion redraw planner: predicts result words and compares them.
`timescale 1ns / 1ps
module lorp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_slot,
  input  logic [7:0]  in_layer_depth,
  input  logic [12:0] in_left,
  input  logic [12:0] in_top,
  input  logic [12:0] in_right,
  input  logic [12:0] in_bottom,
  input  logic        in_buffer_present,
  input  logic        out_valid,
  input  logic [2:0]  out_kind,
  input  logic [2:0]  out_layer_slot,
  input  logic [31:0] out_frames_shown,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_words
);
  import lorp_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] frames;
    logic        last;
  } word_t;

  typedef logic [12:0] rect_t [4];

  word_t      expected_words[$];
  logic       used[8];
  rect_t      rects[8];
  logic [7:0] keys[8];
  logic [2:0] stack[8];
  int         depth_count;
  logic       f_upd[8], f_sgl[8], f_hid[8], f_buf[8];
  logic [31:0] blits[8];
  logic       prev_frame;

  assign pending_words = expected_words.size();

  function automatic logic overlap(rect_t a, rect_t b);
    return !(a[2] <= b[0] || a[0] >= b[2] || a[3] <= b[1] || a[1] >= b[3]);
  endfunction

  function automatic logic contained(rect_t a, rect_t b);
    return a[0] >= b[0] && a[2] <= b[2] && a[1] >= b[1] && a[3] <= b[3];
  endfunction

  task automatic push_word(logic [2:0] k, logic [2:0] s, logic [31:0] f);
    word_t w;
    w.kind = k; w.slot = s; w.frames = f; w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic refresh_flags();
    int s, l, q;
    logic sg, hd, up;
    for (int p = 0; p < depth_count; p++) begin
      s = int'(stack[p]);
      sg = 1; hd = 0; up = 1;
      for (q = depth_count - 1; q >= 0; q--) begin
        if (q == p) begin
          up = 0;
          continue;
        end
        l = int'(stack[q]);
        if (sg) begin
          if (overlap(rects[s], rects[l])) sg = 0;
          else continue;
        end
        if (!hd && up && contained(rects[s], rects[l])) begin
          hd = 1;
          break;
        end
      end
      f_upd[s] = 0; f_sgl[s] = sg; f_hid[s] = hd;
    end
  endtask

  task automatic compose_frame();
    int s;
    logic above;
    above = 0;
    if (depth_count >= 2 && prev_frame) push_word(KIND_COPY, 0, 0);
    for (int p = 0; p < depth_count; p++) begin
      s = int'(stack[p]);
      if (!f_buf[s] || f_hid[s]) continue;
      if (f_sgl[s] && !f_upd[s]) continue;
      if (f_upd[s] && !f_sgl[s]) above = 1;
      if (f_upd[s] && blits[s] != 32'hFFFF_FFFF) blits[s]++;
      if (f_upd[s] || above) push_word(KIND_BLIT, s[2:0], blits[s]);
      f_upd[s] = 0;
    end
    push_word(KIND_FLIP, 0, 0);
    prev_frame = 1;
  endtask

  task automatic plan_request();
    int s, pos, n0;
    rect_t r;
    logic ok, same;
    n0 = expected_words.size();
    r[0] = in_left; r[1] = in_top; r[2] = in_right; r[3] = in_bottom;
    ok = used[in_slot];
    s = int'(in_slot);
    if (in_req_type == REQ_ADD) begin
      for (s = 0; s < 8 && used[s]; s++) ;
      if (s >= 8) push_word(KIND_ERR, 0, 0);
      else begin
        pos = 0;
        while (pos < depth_count && keys[stack[pos]] <= in_layer_depth) pos++;
        for (int i = depth_count; i > pos; i--) stack[i] = stack[i-1];
        stack[pos] = s[2:0];
        depth_count++;
        used[s] = 1; rects[s] = r; keys[s] = in_layer_depth;
        f_upd[s] = 0; f_sgl[s] = 0; f_hid[s] = 0; f_buf[s] = 0; blits[s] = 0;
        push_word(KIND_ACK, s[2:0], 0);
      end
    end else if (in_req_type > REQ_QUERY || (in_req_type != REQ_COMPOSE && !ok)) begin
      push_word(KIND_ERR, 0, 0);
    end else if (in_req_type == REQ_REMOVE) begin
      pos = 0;
      while (pos < depth_count && stack[pos] != in_slot) pos++;
      for (int i = pos; i + 1 < depth_count; i++) stack[i] = stack[i+1];
      if (pos < depth_count) depth_count--;
      used[s] = 0; f_upd[s] = 0; f_sgl[s] = 0; f_hid[s] = 0; f_buf[s] = 0;
      push_word(KIND_ACK, 0, 0);
    end else if (in_req_type == REQ_CONFIG) begin
      same = (rects[s] == r);
      keys[s] = in_layer_depth; rects[s] = r;
      if (!same) refresh_flags();
      push_word(KIND_ACK, 0, 0);
    end else if (in_req_type == REQ_UPDATE) begin
      f_upd[s] = 1; f_buf[s] = in_buffer_present;
      if (depth_count == 1) compose_frame();
      else push_word(KIND_ACK, 0, 0);
    end else if (in_req_type == REQ_COMPOSE) begin
      compose_frame();
    end else begin
      push_word(KIND_ACK, in_slot, blits[s]);
    end
    // flag the closing word of this request
    expected_words[expected_words.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    word_t got, want;
    if (!rst_n) begin
      expected_words.delete();
      for (int i = 0; i < 8; i++) begin
        used[i] = 0; f_upd[i] = 0; f_sgl[i] = 0; f_hid[i] = 0; f_buf[i] = 0;
        blits[i] = 0; keys[i] = 0; stack[i] = 0;
        rects[i] = '{0, 0, 0, 0};
      end
      depth_count = 0; prev_frame = 0; fail_count = 0;
    end else begin
      if (out_valid) begin
        got = '{out_kind, out_layer_slot, out_frames_shown, out_last};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word exp none act %h", $time, got);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.slot !== want.slot ||
              got.frames !== want.frames || got.last !== want.last) begin
            $display("%0t: word mismatch exp k%0d s%0d f%0d l%0d act k%0d s%0d f%0d l%0d",
                     $time, want.kind, want.slot, want.frames, want.last,
                     got.kind, got.slot, got.frames, got.last);
            fail_count++;
          end
        end
      end
      if (start && !busy) plan_request();
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the layer occlusion redraw planner: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import lorp_pkg::*;

  logic        clk, rst_n, start, busy;
  logic [2:0]  in_req_type, in_slot;
  logic [7:0]  in_layer_depth;
  logic [12:0] in_left, in_top, in_right, in_bottom;
  logic        in_buffer_present;
  logic        out_valid, out_last;
  logic [2:0]  out_kind, out_layer_slot;
  logic [31:0] out_frames_shown;
  int          fail_count, pending_words;

  layer_occlusion_redraw_planner_core dut (.*);
  lorp_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Pick a gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int p;
    p = int'($urandom_range(99));
    if (p < 50) return 0;
    if (p < 92) return int'($urandom_range(3, 1));
    return int'($urandom_range(60, 10));
  endfunction

  // Present one request word; hold start until the block takes it.
  task automatic send(logic [2:0] rq, logic [2:0] sl, logic [7:0] dp,
                      logic [12:0] l, logic [12:0] t, logic [12:0] r,
                      logic [12:0] b, logic bp);
    in_req_type = rq; in_slot = sl; in_layer_depth = dp;
    in_left = l; in_top = t; in_right = r; in_bottom = b; in_buffer_present = bp;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
    repeat (gap_len()) @(negedge clk);
  endtask

  // Random rectangle, mostly small and clustered so layers overlap and nest.
  task automatic rand_rect(output logic [12:0] l, t, r, b);
    if ($urandom_range(9) == 0) begin
      l = 13'($urandom); t = 13'($urandom); r = 13'($urandom); b = 13'($urandom);
    end else begin
      l = 13'($urandom_range(40)); t = 13'($urandom_range(40));
      r = 13'(l + 13'($urandom_range(60))); b = 13'(t + 13'($urandom_range(60)));
    end
  endtask

  initial begin
    logic [12:0] l, t, r, b;
    int p;
    start = 0; rst_n = 0;
    in_req_type = 0; in_slot = 0; in_layer_depth = 0;
    in_left = 0; in_top = 0; in_right = 0; in_bottom = 0; in_buffer_present = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: empty compose, errors on free slots and unknown codes.
    send(REQ_COMPOSE, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 3'd7, 0, 0, 0, 0, 0, 0);
    send(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 0);
    send(3'd6, 0, 0, 0, 0, 0, 0, 1);
    send(3'd7, 0, 0, 0, 0, 0, 0, 1);
    // One layer: update composes at once.
    send(REQ_ADD, 0, 8'd0, 0, 0, 13'h1FFF, 13'h1FFF, 0);
    send(REQ_UPDATE, 0, 0, 0, 0, 0, 0, 1);
    // Fill the table with equal and extreme keys, then overflow it.
    for (int i = 0; i < 7; i++)
      send(REQ_ADD, 0, (i == 6) ? 8'hFF : 8'd0, 13'(10 * i), 13'(10 * i),
           13'(100 + i), 13'(100 + i), 0);
    send(REQ_ADD, 0, 8'h80, 0, 0, 1, 1, 0);
    send(REQ_CONFIG, 3'd1, 8'h55, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 0);
    send(REQ_CONFIG, 3'd1, 8'hAA, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 0);
    send(REQ_UPDATE, 3'd7, 0, 0, 0, 0, 0, 1);
    send(REQ_UPDATE, 3'd2, 0, 0, 0, 0, 0, 0);
    send(REQ_UPDATE, 3'd0, 0, 0, 0, 0, 0, 1);
    send(REQ_COMPOSE, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 3'd7, 0, 0, 0, 0, 0, 0);
    send(REQ_REMOVE, 3'd3, 0, 0, 0, 0, 0, 0);
    send(REQ_ADD, 0, 8'h10, 5, 5, 20, 20, 0);

    // Random: mostly updates and composes on a live table, some churn.
    for (int n = 0; n < 240; n++) begin
      p = int'($urandom_range(99));
      rand_rect(l, t, r, b);
      if (p < 12)      send(REQ_ADD, 3'($urandom), 8'($urandom), l, t, r, b,
                            1'($urandom));
      else if (p < 20) send(REQ_REMOVE, 3'($urandom), 8'($urandom), l, t, r, b,
                            1'($urandom));
      else if (p < 35) send(REQ_CONFIG, 3'($urandom), 8'($urandom), l, t, r, b,
                            1'($urandom));
      else if (p < 65) send(REQ_UPDATE, 3'($urandom), 8'($urandom), l, t, r, b,
                            $urandom_range(9) != 0);
      else if (p < 85) send(REQ_COMPOSE, 3'($urandom), 8'($urandom), l, t, r, b,
                            1'($urandom));
      else if (p < 97) send(REQ_QUERY, 3'($urandom), 8'($urandom), l, t, r, b,
                            1'($urandom));
      else             send(3'($urandom_range(7, 6)), 3'($urandom), 8'($urandom),
                            l, t, r, b, 1'($urandom));
    end

    // Drain, then allow settling.
    p = 0;
    while (pending_words != 0 && p < 100000) begin
      @(posedge clk);
      p++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
